### hw/rtl/mfbcd_pkg.sv
// Shared widths, codes and register indexes of the memory field decoder.
package mfbcd_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int VALUE_W    = 64;

  localparam logic [1:0] ENC_BIN  = 2'd0;
  localparam logic [1:0] ENC_BCD  = 2'd1;
  localparam logic [1:0] ENC_BOOL = 2'd2;

  localparam logic [1:0] NIB_WHOLE = 2'd0;
  localparam logic [1:0] NIB_LOW   = 2'd1;
  localparam logic [1:0] NIB_HIGH  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENCODING_MODE  = 4'd0,
    REG_LITTLE_ENDIAN  = 4'd1,
    REG_MASK_ENABLE    = 4'd2,
    REG_UNIT_MASK      = 4'd3,
    REG_INVERT_BOOL    = 4'd4,
    REG_DIGIT_PER_UNIT = 4'd5,
    REG_SCALE_Q16      = 4'd6,
    REG_OFFSET_Q16     = 4'd7
  } cfg_reg_t;

endpackage

### hw/rtl/mfbcd_if.sv
// Channel interfaces of the memory field decoder: unit input, result output, register writes.
interface mfbcd_unit_if import mfbcd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] unit_byte;
  logic [1:0] nibble_select;
  logic       unit_missing;
  logic       last_unit;

  modport source (output valid, output unit_byte, output nibble_select,
                  output unit_missing, output last_unit, input ready);
  modport sink   (input valid, input unit_byte, input nibble_select,
                  input unit_missing, input last_unit, output ready);
endinterface

interface mfbcd_result_if import mfbcd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] field_value;
  logic                      read_failed;

  modport source (output valid, output field_value, output read_failed, input ready);
  modport sink   (input valid, input field_value, input read_failed, output ready);
endinterface

interface mfbcd_cfg_if import mfbcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/memory_field_bcd_int_decoder.sv
// Memory field decoder: folds field units into a value, then scales, offsets and saturates it.
//
// Units of one field arrive one beat at a time on the unit channel; the beat with
// last_unit set closes the field and produces one beat on the result channel.
// Registers are written through the cfg channel, which is always ready; write them
// only while no field is in progress.
// Every product of a 64-bit and a 32-bit operand goes through one shared 32x32 multiplier
// in two passes (S_MLO, S_MHI, then S_COMB): a unit takes one such product in big-endian
// order and two in little-endian order (the place weight is multiplied too). Units beyond
// MAX_UNITS skip the multiplier. The last unit then adds the Q16.16 scale, offset, rounding
// toward zero and saturation (S_FIN, the multiplier, S_SGN, S_SAT) before its result
// reaches S_OUT. A field with a missing unit skips the scaling: S_FIN passes it straight
// to S_OUT.
// The unit channel is ready only while the sequencer is idle.
// Results sit in an output register: the block keeps accepting units while a result
// waits, and holds a new result only if the previous one has still not been taken.
// Reset is synchronous; it restores the register defaults and clears the field state.
module memory_field_bcd_int_decoder
  import mfbcd_pkg::*;
#(
  parameter int MAX_UNITS = 8
) (
  input logic            clk,
  input logic            rst,
  mfbcd_unit_if.sink     unit,
  mfbcd_result_if.source result,
  mfbcd_cfg_if.sink      cfg
);

  localparam int CNT_W = $clog2(MAX_UNITS + 1);
  localparam logic [CNT_W-1:0] UNIT_LIMIT = CNT_W'(MAX_UNITS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MLO  = 8'b0000_0010,
    S_MHI  = 8'b0000_0100,
    S_COMB = 8'b0000_1000,
    S_FIN  = 8'b0001_0000,
    S_SGN  = 8'b0010_0000,
    S_SAT  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_PW    = 2'd1,
    OP_SCALE = 2'd2
  } op_t;

  // Configuration registers.
  logic [1:0]  encoding_mode;
  logic        little_endian;
  logic        mask_enable;
  logic [7:0]  unit_mask;
  logic        invert_bool;
  logic        digit_per_unit;
  logic [31:0] scale_q16;
  logic [31:0] offset_q16;

  // Field state.
  state_t           state;
  logic [63:0]      acc;
  logic [63:0]      pw;
  logic [CNT_W-1:0] units_seen;
  logic             any_missing;

  // Sequencer working registers.
  op_t         op;
  logic        last_r;
  logic        le_r;
  logic [8:0]  radix_r;
  logic [63:0] mx;
  logic [31:0] mb;
  logic [63:0] addend;
  logic [63:0] prod;
  logic [63:0] tmp;
  logic [95:0] mag;
  logic [95:0] sum;
  logic        neg;
  logic [63:0] res_value;
  logic        res_failed;

  // Unit reduction and digit decode.
  logic [7:0] u_sel;
  logic [7:0] u;
  logic [3:0] hi_d;
  logic [3:0] lo_d;
  logic [7:0] chunk;
  logic [7:0] k1;
  logic [8:0] radix_in;
  logic       is_bcd;

  always_comb begin
    case (unit.nibble_select)
      NIB_LOW:  u_sel = {4'd0, unit.unit_byte[3:0]};
      NIB_HIGH: u_sel = {4'd0, unit.unit_byte[7:4]};
      default:  u_sel = unit.unit_byte;
    endcase
    u      = mask_enable ? (u_sel & unit_mask) : u_sel;
    hi_d   = (u[7:4] <= 4'd9) ? u[7:4] : 4'd0;
    lo_d   = (u[3:0] <= 4'd9) ? u[3:0] : 4'd0;
    is_bcd = (encoding_mode == ENC_BCD);
    if (digit_per_unit) begin
      chunk = (u <= 8'd9) ? u : 8'd0;
    end else begin
      chunk = 8'({4'd0, hi_d} * 8'd10) + {4'd0, lo_d};
    end
    k1 = is_bcd ? chunk : u;
    if (is_bcd) begin
      radix_in = digit_per_unit ? 9'd10 : 9'd100;
    end else begin
      radix_in = 9'd256;
    end
  end

  // Value entering the scale step.
  logic        val_bool;
  logic [63:0] fin_val;
  logic [63:0] av;
  logic [31:0] as_mag;

  always_comb begin
    val_bool = (acc != 64'd0) ^ invert_bool;
    fin_val  = (encoding_mode == ENC_BOOL) ? {63'd0, val_bool} : acc;
    av       = fin_val[63] ? (~fin_val + 64'd1) : fin_val;
    as_mag   = scale_q16[31] ? (~scale_q16 + 32'd1) : scale_q16;
  end

  // The shared multiplier: one 32-bit half of mx against mb.
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic [95:0] comb_sum;
  logic [95:0] sgn_sum;
  logic [95:0] rnd_sum;
  logic [79:0] quot;
  logic [63:0] sat_val;

  always_comb begin
    mul_a    = (state == S_MHI) ? mx[63:32] : mx[31:0];
    mul_p    = {32'd0, mul_a} * {32'd0, mb};
    comb_sum = {32'd0, tmp} + {prod, 32'd0};
    sgn_sum  = (neg ? ~mag : mag) + {{64{offset_q16[31]}}, offset_q16} + {95'd0, neg};
    // Adding 0xFFFF before the arithmetic shift rounds a negative sum toward zero.
    rnd_sum  = sum + (sum[95] ? 96'h0_FFFF : 96'd0);
    quot     = rnd_sum[95:16];
    if (!quot[79] && (|quot[79:63])) begin
      sat_val = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (quot[79] && !(&quot[79:63])) begin
      sat_val = 64'h8000_0000_0000_0000;
    end else begin
      sat_val = quot[63:0];
    end
  end

  logic unit_beat;
  logic out_load;

  assign unit.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign unit_beat  = unit.valid && unit.ready;
  assign out_load   = (state == S_OUT) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode  <= ENC_BIN;
      little_endian  <= 1'b0;
      mask_enable    <= 1'b0;
      unit_mask      <= 8'hFF;
      invert_bool    <= 1'b0;
      digit_per_unit <= 1'b0;
      scale_q16      <= 32'h0001_0000;
      offset_q16     <= 32'd0;
      state          <= S_IDLE;
      acc            <= 64'd0;
      pw             <= 64'd1;
      units_seen     <= '0;
      any_missing    <= 1'b0;
      result.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_ENCODING_MODE:  encoding_mode  <= cfg.data[1:0];
          REG_LITTLE_ENDIAN:  little_endian  <= cfg.data[0];
          REG_MASK_ENABLE:    mask_enable    <= cfg.data[0];
          REG_UNIT_MASK:      unit_mask      <= cfg.data[7:0];
          REG_INVERT_BOOL:    invert_bool    <= cfg.data[0];
          REG_DIGIT_PER_UNIT: digit_per_unit <= cfg.data[0];
          REG_SCALE_Q16:      scale_q16      <= cfg.data;
          REG_OFFSET_Q16:     offset_q16     <= cfg.data;
          default: ;
        endcase
      end

      if (result.valid && result.ready && !out_load) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (unit_beat) begin
            any_missing <= any_missing | unit.unit_missing;
            last_r      <= unit.last_unit;
            if (units_seen < UNIT_LIMIT) begin
              units_seen <= units_seen + CNT_W'(1);
              le_r       <= little_endian;
              radix_r    <= radix_in;
              op         <= OP_ACC;
              // Little-endian adds digit * weight; big-endian shifts the total by the radix.
              if (little_endian) begin
                mx     <= pw;
                mb     <= {24'd0, k1};
                addend <= acc;
              end else begin
                mx     <= acc;
                mb     <= {23'd0, radix_in};
                addend <= {56'd0, k1};
              end
              state <= S_MLO;
            end else begin
              state <= unit.last_unit ? S_FIN : S_IDLE;
            end
          end
        end
        S_MLO: begin
          prod  <= mul_p;
          state <= S_MHI;
        end
        S_MHI: begin
          tmp   <= prod + addend;
          prod  <= mul_p;
          state <= S_COMB;
        end
        S_COMB: begin
          case (op)
            OP_ACC: begin
              acc <= comb_sum[63:0];
              if (le_r) begin
                mx     <= pw;
                mb     <= {23'd0, radix_r};
                addend <= 64'd0;
                op     <= OP_PW;
                state  <= S_MLO;
              end else begin
                state <= last_r ? S_FIN : S_IDLE;
              end
            end
            OP_PW: begin
              pw    <= comb_sum[63:0];
              state <= last_r ? S_FIN : S_IDLE;
            end
            OP_SCALE: begin
              mag   <= comb_sum;
              state <= S_SGN;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_FIN: begin
          if (any_missing) begin
            res_value  <= 64'd0;
            res_failed <= 1'b1;
            state      <= S_OUT;
          end else begin
            mx     <= av;
            mb     <= as_mag;
            addend <= 64'd0;
            neg    <= fin_val[63] ^ scale_q16[31];
            op     <= OP_SCALE;
            state  <= S_MLO;
          end
        end
        S_SGN: begin
          sum   <= sgn_sum;
          state <= S_SAT;
        end
        S_SAT: begin
          res_value  <= sat_val;
          res_failed <= 1'b0;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            result.valid       <= 1'b1;
            result.field_value <= res_value;
            result.read_failed <= res_failed;
            acc                <= 64'd0;
            pw                 <= 64'd1;
            units_seen         <= '0;
            any_missing        <= 1'b0;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The unit count never runs past the configured limit.
  a_units_bound: assert property (@(posedge clk) disable iff (rst)
    units_seen <= UNIT_LIMIT)
    else $error("unit count exceeds MAX_UNITS");

  // A failed field always reports zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.read_failed) |-> (result.field_value == 64'sd0))
    else $error("failed field reports a nonzero value");

  // Delivering a result leaves a clean field behind.
  a_field_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (acc == 64'd0 && pw == 64'd1 && units_seen == '0 && !any_missing))
    else $error("field state not cleared after a result");

  // A unit inside the limit always starts the multiplier sequence.
  a_unit_starts: assert property (@(posedge clk) disable iff (rst)
    (unit_beat && units_seen < UNIT_LIMIT) |=> (state == S_MLO))
    else $error("accepted unit did not start the multiplier");

endmodule

### sim/tb_memory_field_bcd_int_decoder.sv
// Self-checking testbench of the memory field decoder: random fields against a field scoreboard.
`timescale 1ns / 1ps

import mfbcd_pkg::*;

class field_scoreboard;
  int unsigned        max_units;
  logic [1:0]         enc;
  bit                 little_end;
  bit                 mask_en;
  logic [7:0]         mask;
  bit                 invert;
  bit                 one_digit;
  logic signed [31:0] scale;
  logic signed [31:0] offset;
  logic [63:0]        acc;
  logic [63:0]        weight;
  int unsigned        seen;
  bit                 saw_missing;
  logic signed [63:0] value_q[$];
  bit                 failed_q[$];
  int                 errors;

  function new(int unsigned units);
    max_units  = units;
    errors     = 0;
    enc        = ENC_BIN;
    little_end = 1'b0;
    mask_en    = 1'b0;
    mask       = 8'hFF;
    invert     = 1'b0;
    one_digit  = 1'b0;
    scale      = 32'sh0001_0000;
    offset     = 32'sh0;
    clear_field();
  endfunction

  function void clear_field();
    acc         = 64'd0;
    weight      = 64'd1;
    seen        = 0;
    saw_missing = 1'b0;
  endfunction

  function void apply_reg(cfg_reg_t idx, logic [31:0] data);
    case (idx)
      REG_ENCODING_MODE:  enc = data[1:0];
      REG_LITTLE_ENDIAN:  little_end = data[0];
      REG_MASK_ENABLE:    mask_en = data[0];
      REG_UNIT_MASK:      mask = data[7:0];
      REG_INVERT_BOOL:    invert = data[0];
      REG_DIGIT_PER_UNIT: one_digit = data[0];
      REG_SCALE_Q16:      scale = data;
      REG_OFFSET_Q16:     offset = data;
      default: ;
    endcase
  endfunction

  function logic [63:0] bcd_digit(logic [3:0] d);
    return (d <= 4'd9) ? {60'd0, d} : 64'd0;
  endfunction

  // Q16.16 scale and offset, truncated toward zero and clamped to 64 bits.
  function logic signed [63:0] scale_and_offset(logic [63:0] v);
    logic signed [127:0] v_w, s_w, o_w, sum, q;
    v_w = $signed(v);
    s_w = scale;
    o_w = offset;
    sum = v_w * s_w + o_w;
    if (sum < 0) begin
      q = (-sum) >> 16;
      if (q > 128'sh8000_0000_0000_0000)
        return 64'sh8000_0000_0000_0000;
      return -q[63:0];
    end
    q = sum >> 16;
    if (q > 128'sh7FFF_FFFF_FFFF_FFFF)
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    return q[63:0];
  endfunction

  function void queue_expected(logic signed [63:0] value, bit failed);
    value_q.insert(value_q.size(), value);
    failed_q.insert(failed_q.size(), failed);
  endfunction

  function void accept_unit(logic [7:0] raw, logic [1:0] sel, bit missing, bit last);
    logic [63:0] u, chunk, radix, v;
    if (missing)
      saw_missing = 1'b1;
    if (seen < max_units) begin
      case (sel)
        NIB_LOW:  u = {60'd0, raw[3:0]};
        NIB_HIGH: u = {60'd0, raw[7:4]};
        default:  u = {56'd0, raw};
      endcase
      if (mask_en)
        u = u & {56'd0, mask};
      if (enc == ENC_BCD) begin
        if (one_digit) begin
          chunk = (u <= 64'd9) ? u : 64'd0;
          radix = 64'd10;
        end else begin
          chunk = bcd_digit(u[7:4]) * 64'd10 + bcd_digit(u[3:0]);
          radix = 64'd100;
        end
        if (little_end) begin
          acc    = acc + chunk * weight;
          weight = weight * radix;
        end else begin
          acc = acc * radix + chunk;
        end
      end else if (little_end) begin
        acc    = acc + u * weight;
        weight = weight << 8;
      end else begin
        acc = (acc << 8) | u;
      end
      seen++;
    end
    if (last) begin
      if (saw_missing) begin
        queue_expected(64'sd0, 1'b1);
      end else begin
        v = acc;
        if (enc == ENC_BOOL)
          v = {63'd0, (acc != 64'd0) ^ invert};
        queue_expected(scale_and_offset(v), 1'b0);
      end
      clear_field();
    end
  endfunction

  function void check_result(logic signed [63:0] value, logic failed);
    logic signed [63:0] want_value;
    bit                 want_failed;
    if (value_q.size() == 0) begin
      errors++;
      $display("%0t: result beat with nothing expected: field_value=%0d read_failed=%0b",
               $time, value, failed);
      return;
    end
    want_value  = value_q.pop_front();
    want_failed = failed_q.pop_front();
    if (value !== want_value) begin
      errors++;
      $display("%0t: field_value mismatch: expected %0d, actual %0d", $time, want_value, value);
    end
    if (failed !== want_failed) begin
      errors++;
      $display("%0t: read_failed mismatch: expected %0b, actual %0b", $time, want_failed, failed);
    end
  endfunction

  function int pending();
    return value_q.size();
  endfunction
endclass

module tb_memory_field_bcd_int_decoder;
  localparam int MAX_UNITS       = 8;
  localparam int SETTLE_CYCLES   = 20;
  localparam int PHASES          = 24;
  localparam int UNITS_PER_PHASE = 44;
  localparam int LONG_HOLD       = 400;
  localparam logic [1:0] ENC_UNUSED = 2'd3;
  localparam logic [1:0] NIB_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle_pct  = 13;
  int   sink_idle_pct = 69;
  int   stall_request = 0;
  logic [1:0] cur_enc = ENC_BIN;
  field_scoreboard field_sb;

  mfbcd_unit_if   unit_ch();
  mfbcd_result_if result_ch();
  mfbcd_cfg_if    cfg_ch();

  memory_field_bcd_int_decoder #(.MAX_UNITS(MAX_UNITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .unit   (unit_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Beats are sampled at the rising edge, before the block updates its outputs.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        field_sb.apply_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
      if (unit_ch.valid && unit_ch.ready)
        field_sb.accept_unit(unit_ch.unit_byte, unit_ch.nibble_select,
                             unit_ch.unit_missing, unit_ch.last_unit);
      if (result_ch.valid && result_ch.ready)
        field_sb.check_result(result_ch.field_value, result_ch.read_failed);
    end
  end

  // Result receiver: random back-pressure, plus a long hold when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    if (idx == REG_ENCODING_MODE)
      cur_enc = data[1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // Valid stays high across back-to-back beats; it only drops for a gap.
  task automatic send_unit(logic [7:0] raw, logic [1:0] sel, bit missing, bit last);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct)
      gap++;
    @(negedge clk);
    if (gap > 0) begin
      unit_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    unit_ch.valid         <= 1'b1;
    unit_ch.unit_byte     <= raw;
    unit_ch.nibble_select <= sel;
    unit_ch.unit_missing  <= missing;
    unit_ch.last_unit     <= last;
    do @(posedge clk); while (!unit_ch.ready);
  endtask

  // Stop sending and wait until every expected result is in, then let the block go quiet.
  task automatic settle();
    @(negedge clk) unit_ch.valid <= 1'b0;
    while (field_sb.pending() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_field(int n);
    logic [7:0] raw;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       raw = 8'h00;
        1:       raw = 8'hFF;
        2, 3, 4: raw = (cur_enc == ENC_BCD) ?
                       {4'($urandom_range(9)), 4'($urandom_range(9))} : 8'($urandom);
        default: raw = 8'($urandom);
      endcase
      send_unit(raw, 2'($urandom_range(3)), $urandom_range(99) < 4, i == n - 1);
    end
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'd0;
      3:       return 32'h0001_0000;
      4:       return 32'hFFFF_0000;
      5:       return 32'($urandom_range(32'h0010_0000));
      6:       return -32'($urandom_range(32'h0010_0000));
      default: return $urandom;
    endcase
  endfunction

  task automatic randomize_regs(int phase);
    logic [31:0] scale_val, offset_val, mask_val;
    scale_val  = (phase == 0) ? 32'h8000_0000 : (phase == 1) ? 32'h7FFF_FFFF : pick_q16();
    offset_val = (phase == 0) ? 32'h7FFF_FFFF : (phase == 1) ? 32'h8000_0000 : pick_q16();
    case ($urandom_range(3))
      0:       mask_val = 32'h00;
      1:       mask_val = 32'hFF;
      default: mask_val = 32'($urandom_range(255));
    endcase
    write_reg(REG_ENCODING_MODE, $urandom_range(3));
    write_reg(REG_LITTLE_ENDIAN, $urandom_range(1));
    write_reg(REG_MASK_ENABLE, $urandom_range(1));
    write_reg(REG_UNIT_MASK, mask_val);
    write_reg(REG_INVERT_BOOL, $urandom_range(1));
    write_reg(REG_DIGIT_PER_UNIT, $urandom_range(1));
    write_reg(REG_SCALE_Q16, scale_val);
    write_reg(REG_OFFSET_Q16, offset_val);
  endtask

  initial begin
    int sent;
    int n;
    bit held;
    bit paused;
    field_sb = new(MAX_UNITS);
    unit_ch.valid         = 1'b0;
    unit_ch.unit_byte     = 8'h00;
    unit_ch.nibble_select = NIB_WHOLE;
    unit_ch.unit_missing  = 1'b0;
    unit_ch.last_unit     = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_ENCODING_MODE;
    cfg_ch.data           = 32'd0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed fields under the reset settings: binary, big-endian, scale 1.0.
    send_unit(8'hFF, NIB_WHOLE, 1'b0, 1'b1);
    send_unit(8'h00, NIB_WHOLE, 1'b0, 1'b1);
    send_unit(8'hA5, NIB_LOW, 1'b0, 1'b0);
    send_unit(8'hA5, NIB_HIGH, 1'b0, 1'b0);
    send_unit(8'hA5, NIB_UNUSED, 1'b0, 1'b1);
    send_unit(8'h12, NIB_WHOLE, 1'b0, 1'b0);
    send_unit(8'h34, NIB_WHOLE, 1'b1, 1'b0);
    send_unit(8'h56, NIB_WHOLE, 1'b0, 1'b1);
    // One unit past MAX_UNITS: the surplus unit only closes the field.
    for (int i = 0; i <= MAX_UNITS; i++)
      send_unit(8'hFF, NIB_WHOLE, 1'b0, i == MAX_UNITS);
    settle();

    write_reg(REG_ENCODING_MODE, 32'(ENC_BCD));
    write_reg(REG_LITTLE_ENDIAN, 1);
    send_unit(8'h99, NIB_WHOLE, 1'b0, 1'b0);
    send_unit(8'hAB, NIB_WHOLE, 1'b0, 1'b1);
    settle();
    write_reg(REG_DIGIT_PER_UNIT, 1);
    send_unit(8'h07, NIB_WHOLE, 1'b0, 1'b0);
    send_unit(8'h0C, NIB_WHOLE, 1'b0, 1'b1);
    settle();

    write_reg(REG_ENCODING_MODE, 32'(ENC_BOOL));
    write_reg(REG_INVERT_BOOL, 1);
    send_unit(8'h00, NIB_WHOLE, 1'b0, 1'b1);
    settle();
    write_reg(REG_ENCODING_MODE, 32'(ENC_UNUSED));
    send_unit(8'h80, NIB_WHOLE, 1'b0, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 3) begin
        src_idle_pct  = 69;
        sink_idle_pct = 13;
      end else if (phase == 2 * PHASES / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      settle();
      randomize_regs(phase);
      sent = 0;
      while (sent < UNITS_PER_PHASE) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(MAX_UNITS + 4, MAX_UNITS + 1)
                                     : $urandom_range(MAX_UNITS, 1);
        send_field(n);
        sent += n;
        // The receiver holds off while units keep coming, so the output register backs up.
        if (phase == 3 && !held) begin
          held          = 1'b1;
          stall_request = LONG_HOLD;
        end
        if (phase == 5 && !paused && sent >= UNITS_PER_PHASE / 2) begin
          paused = 1'b1;
          settle();
        end
      end
    end
    settle();

    if (field_sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
